[hdl/csa_pkg.sv]
// ----------------------------------------------------------------------------
// csa_pkg
// Shared codes and types of the contiguous segment allocator.
// ----------------------------------------------------------------------------
package csa_pkg;

    localparam int OWN_W = 16;
    localparam int CFG_W = 17;

    localparam logic [2:0] OP_REQ  = 3'd0;
    localparam logic [2:0] OP_REL  = 3'd1;
    localparam logic [2:0] OP_CMP  = 3'd2;
    localparam logic [2:0] OP_STAT = 3'd3;
    localparam logic [2:0] OP_INIT = 3'd4;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NO_SPACE = 3'd1;
    localparam logic [2:0] ST_DUP_ID   = 3'd2;
    localparam logic [2:0] ST_NOT_FND  = 3'd3;
    localparam logic [2:0] ST_BAD_MODE = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_ZERO     = 3'd6;

    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;
    localparam logic [1:0] FIT_BAD   = 2'd3;

    typedef enum logic [1:0] {
        AOP_ADD   = 2'd0,
        AOP_SUB   = 2'd1,
        AOP_ADDM1 = 2'd2
    } t_aop;

    typedef enum logic [1:0] {
        TC_NONE  = 2'd0,
        TC_WR    = 2'd1,
        TC_SPLIT = 2'd2,
        TC_DEL   = 2'd3
    } t_tcmd;

endpackage

[hdl/contiguous_segment_allocator.sv]
// ----------------------------------------------------------------------------
// contiguous_segment_allocator
// First, best and worst fit allocator over an address-ordered segment table.
// ----------------------------------------------------------------------------
// A request scans the table, then S_RQ_CHK, S_RQ_PUT, S_RQ_TOT and S_RQ_END
// (refused: stops at S_RQ_CHK); a release scans, then S_RL_HIT, S_RL_NXT,
// S_RL_PRV and S_RL_END (not found: stops at S_RL_HIT); compact scans, then
// S_CP_TOP and, with a top segment, S_CP_END; init uses S_IN, status S_ST.
// A scan reads one entry per cycle. One item at a time: the next is taken
// after the last result transfer; each further status result passes through
// S_ST again. S_BOOT builds the single free segment after reset.
// ----------------------------------------------------------------------------
module contiguous_segment_allocator #(
    parameter int MAX_SEGMENTS = 16,
    parameter int ADDR_BITS    = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    output logic                      o_stall,
    input  logic [2:0]                i_op,
    input  logic [csa_pkg::OWN_W-1:0] i_owner_id,
    input  logic [ADDR_BITS:0]        i_req_size,
    input  logic [1:0]                i_fit_mode,
    output logic                      o_valid,
    input  logic                      i_stall,
    output logic [2:0]                o_status,
    output logic [ADDR_BITS-1:0]      o_seg_start,
    output logic [ADDR_BITS-1:0]      o_seg_end,
    output logic [csa_pkg::OWN_W-1:0] o_seg_owner,
    output logic                      o_seg_is_free,
    output logic [ADDR_BITS:0]        o_total_free_out,
    output logic                      o_last,
    input  logic                      psel,
    input  logic                      penable,
    input  logic                      pwrite,
    input  logic [2:0]                paddr,
    input  logic [31:0]               pwdata,
    output logic [31:0]               prdata,
    output logic                      pready
);
    import csa_pkg::*;

    localparam int AW = ADDR_BITS;
    localparam int SW = ADDR_BITS + 1;
    localparam int IW = $clog2(MAX_SEGMENTS);
    localparam int CW = $clog2(MAX_SEGMENTS + 1);
    localparam int WW = (SW > CFG_W) ? SW : CFG_W;
    localparam logic [SW-1:0] LIM = {1'b1, {AW{1'b0}}};
    localparam logic [CW-1:0] MAXC = CW'(MAX_SEGMENTS);

    typedef enum logic [17:0] {
        S_BOOT    = 18'h00001,
        S_IDLE    = 18'h00002,
        S_RQ_SCAN = 18'h00004,
        S_RQ_CHK  = 18'h00008,
        S_RQ_PUT  = 18'h00010,
        S_RQ_TOT  = 18'h00020,
        S_RQ_END  = 18'h00040,
        S_RL_SCAN = 18'h00080,
        S_RL_HIT  = 18'h00100,
        S_RL_NXT  = 18'h00200,
        S_RL_PRV  = 18'h00400,
        S_RL_END  = 18'h00800,
        S_CP_SCAN = 18'h01000,
        S_CP_TOP  = 18'h02000,
        S_CP_END  = 18'h04000,
        S_ST      = 18'h08000,
        S_IN      = 18'h10000,
        S_WAIT    = 18'h20000
    } t_state;

    t_state            r_state;
    logic [2:0]        r_op;
    logic [OWN_W-1:0]  r_own;
    logic [SW-1:0]     r_req;
    logic [1:0]        r_mode;
    logic [IW-1:0]     r_idx;
    logic [CW-1:0]     r_count;
    logic [SW-1:0]     r_total;
    logic [CFG_W-1:0]  r_mem;
    logic              r_dup;
    logic              r_found;
    logic [IW-1:0]     r_pick;
    logic [SW-1:0]     r_psize;
    logic [SW-1:0]     r_left;
    logic [AW-1:0]     r_a;
    logic [SW-1:0]     r_sz;
    logic [SW-1:0]     r_acc;
    logic [SW-1:0]     r_addr;
    logic [CW-1:0]     r_n;
    logic              r_ov;
    logic [2:0]        r_ost;
    logic [AW-1:0]     r_ostart;
    logic [AW-1:0]     r_oend;
    logic [OWN_W-1:0]  r_oown;
    logic              r_ofree;
    logic              r_olast;

    t_aop              alu_op;
    logic [SW-1:0]     alu_a;
    logic [SW-1:0]     alu_b;
    logic [SW-1:0]     alu_y;
    logic              alu_borrow;

    t_tcmd             tb_cmd;
    logic [IW-1:0]     tb_idx;
    logic [AW-1:0]     tb_d0_start;
    logic [SW-1:0]     tb_d0_size;
    logic [OWN_W-1:0]  tb_d0_owner;
    logic              tb_d0_free;
    logic [IW-1:0]     rd_idx;
    logic [AW-1:0]     rd_start;
    logic [SW-1:0]     rd_size;
    logic [OWN_W-1:0]  rd_owner;
    logic              rd_free;

    logic [WW-1:0]     m_w;
    logic [SW-1:0]     m_clamp;
    logic              scan_last;
    logic              fits;
    logic              nxt_ok;
    logic              cfg_wr;

    assign m_w     = WW'(r_mem);
    assign m_clamp = (m_w < WW'(2)) ? SW'(2) : ((m_w > WW'(LIM)) ? LIM : SW'(m_w));

    assign scan_last = (CW'(r_idx) + CW'(1)) == r_count;
    assign fits      = rd_free && !alu_borrow;
    assign nxt_ok    = (CW'(r_pick) + CW'(1)) < r_count;

    // one table read address per cycle
    always_comb begin
        unique case (r_state)
            S_RQ_PUT, S_RL_HIT: rd_idx = r_pick;
            S_RL_NXT:           rd_idx = r_pick + IW'(1);
            S_RL_PRV:           rd_idx = r_pick - IW'(1);
            default:            rd_idx = r_idx;
        endcase
    end

    always_comb begin
        alu_op = AOP_ADD;
        alu_a  = r_acc;
        alu_b  = rd_size;
        unique case (r_state)
            S_RQ_SCAN: begin alu_op = AOP_SUB; alu_a = rd_size; alu_b = r_req; end
            S_RQ_PUT:  begin alu_a = {1'b0, rd_start}; alu_b = r_req; end
            S_RQ_TOT:  begin alu_op = AOP_SUB; alu_a = r_total; alu_b = r_req; end
            S_RQ_END:  begin alu_op = AOP_ADDM1; alu_a = {1'b0, r_a}; alu_b = r_req; end
            S_RL_HIT:  begin alu_a = r_total; alu_b = rd_size; end
            S_RL_NXT:  begin alu_a = r_psize; alu_b = rd_size; end
            S_RL_PRV:  begin alu_a = rd_size; alu_b = r_psize; end
            S_RL_END:  begin alu_op = AOP_ADDM1; alu_a = {1'b0, r_a}; alu_b = r_sz; end
            S_CP_SCAN: begin alu_a = rd_free ? r_acc : r_addr; alu_b = rd_size; end
            S_CP_END:  begin alu_op = AOP_ADDM1; alu_a = r_addr; alu_b = r_acc; end
            S_ST:      begin alu_op = AOP_ADDM1; alu_a = {1'b0, rd_start}; alu_b = rd_size; end
            S_IN:      begin alu_op = AOP_ADDM1; alu_a = '0; alu_b = m_clamp; end
            default: ;
        endcase
    end

    csa_alu #(.W(SW)) u_alu (
        .i_a      (alu_a),
        .i_b      (alu_b),
        .i_op     (alu_op),
        .o_y      (alu_y),
        .o_borrow (alu_borrow)
    );

    always_comb begin
        tb_cmd      = TC_NONE;
        tb_idx      = r_pick;
        tb_d0_start = rd_start;
        tb_d0_size  = rd_size;
        tb_d0_owner = '0;
        tb_d0_free  = 1'b1;
        unique case (r_state)
            S_BOOT, S_IN: begin
                tb_cmd      = TC_WR;
                tb_idx      = '0;
                tb_d0_start = '0;
                tb_d0_size  = m_clamp;
            end
            S_RQ_PUT: begin
                tb_cmd      = (r_left != '0) ? TC_SPLIT : TC_WR;
                tb_d0_size  = r_req;
                tb_d0_owner = r_own;
                tb_d0_free  = 1'b0;
            end
            S_RL_HIT: begin
                if (r_found) tb_cmd = TC_WR;
            end
            S_RL_NXT: begin
                if (nxt_ok && rd_free) tb_cmd = TC_DEL;
                tb_d0_start = r_a;
                tb_d0_size  = alu_y;
            end
            S_RL_PRV: begin
                if ((r_pick != '0) && rd_free) tb_cmd = TC_DEL;
                tb_idx     = r_pick - IW'(1);
                tb_d0_size = alu_y;
            end
            S_CP_SCAN: begin
                if (!rd_free) tb_cmd = TC_WR;
                tb_idx      = IW'(r_n);
                tb_d0_start = r_addr[AW-1:0];
                tb_d0_owner = rd_owner;
                tb_d0_free  = 1'b0;
            end
            S_CP_TOP: begin
                if ((r_acc != '0) && (r_n < MAXC)) tb_cmd = TC_WR;
                tb_idx      = IW'(r_n);
                tb_d0_start = r_addr[AW-1:0];
                tb_d0_size  = r_acc;
            end
            default: ;
        endcase
    end

    csa_table #(.N(MAX_SEGMENTS), .AW(AW), .SW(SW), .IW(IW)) u_table (
        .i_clk      (i_clk),
        .i_cmd      (tb_cmd),
        .i_idx      (tb_idx),
        .i_d0_start (tb_d0_start),
        .i_d0_size  (tb_d0_size),
        .i_d0_owner (tb_d0_owner),
        .i_d0_free  (tb_d0_free),
        .i_d1_start (alu_y[AW-1:0]),
        .i_d1_size  (r_left),
        .i_d1_free  (1'b1),
        .i_rd_idx   (rd_idx),
        .o_rd_start (rd_start),
        .o_rd_size  (rd_size),
        .o_rd_owner (rd_owner),
        .o_rd_free  (rd_free)
    );

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_BOOT;
            r_ov    <= 1'b0;
            r_count <= CW'(1);
            r_total <= '0;
            r_mem   <= CFG_W'(65536);
        end else begin
            if (cfg_wr) r_mem <= pwdata[CFG_W-1:0];
            unique case (r_state)
                S_BOOT: begin
                    r_count <= CW'(1);
                    r_total <= m_clamp;
                    r_state <= S_IDLE;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_op    <= i_op;
                        r_own   <= i_owner_id;
                        r_req   <= i_req_size;
                        r_mode  <= i_fit_mode;
                        r_idx   <= '0;
                        r_dup   <= 1'b0;
                        r_found <= 1'b0;
                        r_acc   <= '0;
                        r_addr  <= '0;
                        r_n     <= '0;
                        case (i_op)
                            OP_REQ:  r_state <= S_RQ_SCAN;
                            OP_REL:  r_state <= S_RL_SCAN;
                            OP_CMP:  r_state <= S_CP_SCAN;
                            OP_STAT: r_state <= S_ST;
                            OP_INIT: r_state <= S_IN;
                            default: r_state <= S_IDLE;
                        endcase
                    end
                end
                S_RQ_SCAN: begin
                    if (!rd_free && (rd_owner == r_own)) r_dup <= 1'b1;
                    if (fits && (!r_found ||
                        ((r_mode == FIT_BEST) && (rd_size < r_psize)) ||
                        ((r_mode == FIT_WORST) && (rd_size > r_psize)))) begin
                        r_found <= 1'b1;
                        r_pick  <= r_idx;
                        r_psize <= rd_size;
                        r_left  <= alu_y;
                    end
                    r_idx <= r_idx + IW'(1);
                    if (scan_last) r_state <= S_RQ_CHK;
                end
                S_RQ_CHK: begin
                    r_ostart <= '0;
                    r_oend   <= '0;
                    r_oown   <= '0;
                    r_ofree  <= 1'b0;
                    r_olast  <= 1'b1;
                    if (r_dup || (r_mode == FIT_BAD) || (r_req == '0) || !r_found ||
                        ((r_left != '0) && (r_count >= MAXC))) begin
                        r_ov    <= 1'b1;
                        r_state <= S_WAIT;
                    end else begin
                        r_state <= S_RQ_PUT;
                    end
                    if (r_dup) begin
                        r_ost <= ST_DUP_ID;
                    end else if (r_mode == FIT_BAD) begin
                        r_ost <= ST_BAD_MODE;
                    end else if (r_req == '0) begin
                        r_ost <= ST_ZERO;
                    end else if (!r_found) begin
                        r_ost <= ST_NO_SPACE;
                    end else if ((r_left != '0) && (r_count >= MAXC)) begin
                        r_ost <= ST_FULL;
                    end
                end
                S_RQ_PUT: begin
                    r_a <= rd_start;
                    if (r_left != '0) r_count <= r_count + CW'(1);
                    r_state <= S_RQ_TOT;
                end
                S_RQ_TOT: begin
                    r_total <= alu_borrow ? '0 : alu_y;
                    r_state <= S_RQ_END;
                end
                S_RQ_END: begin
                    r_ov     <= 1'b1;
                    r_ost    <= ST_OK;
                    r_ostart <= r_a;
                    r_oend   <= alu_y[AW-1:0];
                    r_oown   <= r_own;
                    r_ofree  <= 1'b0;
                    r_olast  <= 1'b1;
                    r_state  <= S_WAIT;
                end
                S_RL_SCAN: begin
                    if (!rd_free && (rd_owner == r_own) && !r_found) begin
                        r_found <= 1'b1;
                        r_pick  <= r_idx;
                    end
                    r_idx <= r_idx + IW'(1);
                    if (scan_last) r_state <= S_RL_HIT;
                end
                S_RL_HIT: begin
                    if (!r_found) begin
                        r_ov     <= 1'b1;
                        r_ost    <= ST_NOT_FND;
                        r_ostart <= '0;
                        r_oend   <= '0;
                        r_oown   <= '0;
                        r_ofree  <= 1'b0;
                        r_olast  <= 1'b1;
                        r_state  <= S_WAIT;
                    end else begin
                        r_a     <= rd_start;
                        r_sz    <= rd_size;
                        r_psize <= rd_size;
                        r_total <= alu_y;
                        r_state <= S_RL_NXT;
                    end
                end
                S_RL_NXT: begin
                    if (nxt_ok && rd_free) begin
                        r_psize <= alu_y;
                        r_count <= r_count - CW'(1);
                    end
                    r_state <= S_RL_PRV;
                end
                S_RL_PRV: begin
                    if ((r_pick != '0) && rd_free) r_count <= r_count - CW'(1);
                    r_state <= S_RL_END;
                end
                S_RL_END: begin
                    r_ov     <= 1'b1;
                    r_ost    <= ST_OK;
                    r_ostart <= r_a;
                    r_oend   <= alu_y[AW-1:0];
                    r_oown   <= r_own;
                    r_ofree  <= 1'b1;
                    r_olast  <= 1'b1;
                    r_state  <= S_WAIT;
                end
                S_CP_SCAN: begin
                    if (rd_free) begin
                        r_acc <= alu_y;
                    end else begin
                        r_addr <= alu_y;
                        r_n    <= r_n + CW'(1);
                    end
                    r_idx <= r_idx + IW'(1);
                    if (scan_last) r_state <= S_CP_TOP;
                end
                S_CP_TOP: begin
                    r_total <= r_acc;
                    if ((r_acc != '0) && (r_n < MAXC)) begin
                        r_count <= r_n + CW'(1);
                        r_state <= S_CP_END;
                    end else begin
                        r_count  <= r_n;
                        r_ov     <= 1'b1;
                        r_ost    <= ST_OK;
                        r_ostart <= '0;
                        r_oend   <= '0;
                        r_oown   <= '0;
                        r_ofree  <= 1'b0;
                        r_olast  <= 1'b1;
                        r_state  <= S_WAIT;
                    end
                end
                S_CP_END: begin
                    r_ov     <= 1'b1;
                    r_ost    <= ST_OK;
                    r_ostart <= r_addr[AW-1:0];
                    r_oend   <= alu_y[AW-1:0];
                    r_oown   <= '0;
                    r_ofree  <= 1'b1;
                    r_olast  <= 1'b1;
                    r_state  <= S_WAIT;
                end
                S_ST: begin
                    r_ov     <= 1'b1;
                    r_ost    <= ST_OK;
                    r_ostart <= rd_start;
                    r_oend   <= alu_y[AW-1:0];
                    r_oown   <= rd_free ? '0 : rd_owner;
                    r_ofree  <= rd_free;
                    r_olast  <= scan_last;
                    r_state  <= S_WAIT;
                end
                S_IN: begin
                    r_count  <= CW'(1);
                    r_total  <= m_clamp;
                    r_ov     <= 1'b1;
                    r_ost    <= ST_OK;
                    r_ostart <= '0;
                    r_oend   <= alu_y[AW-1:0];
                    r_oown   <= '0;
                    r_ofree  <= 1'b1;
                    r_olast  <= 1'b1;
                    r_state  <= S_WAIT;
                end
                S_WAIT: begin
                    if (!i_stall) begin
                        r_ov <= 1'b0;
                        if ((r_op == OP_STAT) && !r_olast) begin
                            r_idx   <= r_idx + IW'(1);
                            r_state <= S_ST;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_stall          = (r_state != S_IDLE);
    assign o_valid          = r_ov;
    assign o_status         = r_ost;
    assign o_seg_start      = r_ostart;
    assign o_seg_end        = r_oend;
    assign o_seg_owner      = r_oown;
    assign o_seg_is_free    = r_ofree;
    assign o_total_free_out = r_total;
    assign o_last           = r_olast;
    assign prdata           = (paddr[2] == 1'b0) ? 32'(r_mem) : 32'd0;
    assign pready           = 1'b1;

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != '0) && (r_count <= MAXC))
        else $error("segment count out of range");

    a_total_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_total <= LIM)
        else $error("free total above memory limit");

    a_valid_in_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (r_state == S_WAIT))
        else $error("result shown outside wait state");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall && (i_op == OP_REQ || i_op == OP_REL || i_op == OP_CMP ||
         i_op == OP_STAT || i_op == OP_INIT)) |=> o_stall)
        else $error("block not busy after transfer");

    a_split_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (tb_cmd == TC_SPLIT) |-> (r_count < MAXC))
        else $error("split into full table");

endmodule

[hdl/csa_alu.sv]
// ----------------------------------------------------------------------------
// csa_alu
// Shared adder and subtractor of the allocator sequencer.
// ----------------------------------------------------------------------------
module csa_alu #(
    parameter int W = 17
) (
    input  logic [W-1:0]      i_a,
    input  logic [W-1:0]      i_b,
    input  csa_pkg::t_aop     i_op,
    output logic [W-1:0]      o_y,
    output logic              o_borrow
);
    import csa_pkg::*;

    logic [W:0] w_y;

    always_comb begin
        case (i_op)
            AOP_SUB:   w_y = {1'b0, i_a} - {1'b0, i_b};
            AOP_ADDM1: w_y = {1'b0, i_a} + {1'b0, i_b} - (W+1)'(1);
            default:   w_y = {1'b0, i_a} + {1'b0, i_b};
        endcase
    end

    assign o_y      = w_y[W-1:0];
    assign o_borrow = (i_op == AOP_SUB) && w_y[W];

endmodule

[hdl/csa_table.sv]
// ----------------------------------------------------------------------------
// csa_table
// Address-ordered segment table with one read port and in-place split and
// delete shifts.
// ----------------------------------------------------------------------------
module csa_table #(
    parameter int N  = 16,
    parameter int AW = 16,
    parameter int SW = 17,
    parameter int IW = 4
) (
    input  logic                      i_clk,
    input  csa_pkg::t_tcmd            i_cmd,
    input  logic [IW-1:0]             i_idx,
    input  logic [AW-1:0]             i_d0_start,
    input  logic [SW-1:0]             i_d0_size,
    input  logic [csa_pkg::OWN_W-1:0] i_d0_owner,
    input  logic                      i_d0_free,
    input  logic [AW-1:0]             i_d1_start,
    input  logic [SW-1:0]             i_d1_size,
    input  logic                      i_d1_free,
    input  logic [IW-1:0]             i_rd_idx,
    output logic [AW-1:0]             o_rd_start,
    output logic [SW-1:0]             o_rd_size,
    output logic [csa_pkg::OWN_W-1:0] o_rd_owner,
    output logic                      o_rd_free
);
    import csa_pkg::*;

    typedef struct packed {
        logic [AW-1:0]    st;
        logic [SW-1:0]    sz;
        logic [OWN_W-1:0] own;
        logic             fr;
    } t_ent;

    t_ent r_ent [N];
    t_ent w_d0;
    t_ent w_d1;

    assign w_d0 = '{st: i_d0_start, sz: i_d0_size, own: i_d0_owner, fr: i_d0_free};
    assign w_d1 = '{st: i_d1_start, sz: i_d1_size, own: '0, fr: i_d1_free};

    for (genvar j = 0; j < N; j++) begin : g_ent
        localparam int JP = (j > 0) ? j - 1 : 0;
        localparam int JN = (j < N - 1) ? j + 1 : j;
        always_ff @(posedge i_clk) begin
            case (i_cmd)
                TC_WR: begin
                    if (j == int'(i_idx)) r_ent[j] <= w_d0;
                end
                TC_SPLIT: begin
                    if (j == int'(i_idx)) begin
                        r_ent[j] <= w_d0;
                    end else if (j == int'(i_idx) + 1) begin
                        r_ent[j] <= w_d1;
                    end else if (j > int'(i_idx) + 1) begin
                        r_ent[j] <= r_ent[JP];
                    end
                end
                TC_DEL: begin
                    if (j == int'(i_idx)) begin
                        r_ent[j] <= w_d0;
                    end else if (j > int'(i_idx)) begin
                        r_ent[j] <= r_ent[JN];
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_rd_start = r_ent[i_rd_idx].st;
    assign o_rd_size  = r_ent[i_rd_idx].sz;
    assign o_rd_owner = r_ent[i_rd_idx].own;
    assign o_rd_free  = r_ent[i_rd_idx].fr;

endmodule
